// ===== hdl/bffa_pkg.sv =====
// bffa_pkg: types, codes and default sizes of the first-fit bitmap block allocator
// used by bitmap_first_fit_allocator_core; depends on nothing else
package bffa_pkg;

    localparam int DEF_BLOCK_BYTES   = 4096;
    localparam int DEF_MAP_BLOCKS    = 4096;
    localparam int DEF_MAX_ENTRIES   = 256;
    localparam int TOTAL_W           = 13;
    localparam int RESET_TOTAL_BLOCKS = 4096;

    typedef enum logic [1:0] {
        FN_ALLOC     = 2'd0,
        FN_RESERVE   = 2'd1,
        FN_REL_START = 2'd2,
        FN_REL_OWNER = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_SIZE   = 3'd1,
        STAT_TABLE_FULL = 3'd2,
        STAT_BAD_ALIGN  = 3'd3,
        STAT_NO_MEM     = 3'd4,
        STAT_NO_ENTRY   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ALLOC_RD,
        S_ALLOC_EV,
        S_TBL_RD,
        S_TBL_EV,
        S_MK_SET,
        S_MARK,
        S_POST,
        S_MOVE_WR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [15:0] owner;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
    } entry_t;

endpackage

// ===== hdl/bitmap_first_fit_allocator_core.sv =====
// bitmap_first_fit_allocator_core: first-fit block allocator over a used-block bitmap
// memory and an entry table memory; depends on bffa_pkg
//
// usage
//   s_tvalid/s_tready/s_tuser/s_tdata carry one request word, m_tvalid/m_tready/m_tuser/
//   m_tdata one answer word per request. cfg_valid/cfg_ready/cfg_data write total_blocks
//   (the user writes only while the block is idle; the block does not enforce it);
//   cfg_ready is always high. requests are handled one at a time, in these steps:
//     allocate: early error checks, then a bitmap scan for a free run, then marking
//       each block of the run that fits
//     reserve: table-full check, then marking each block of the range
//     release: table entries examined in turn; each entry dropped clears its blocks
//       and may move the last entry into its slot; a release by start stops at its entry
//   the scan reads one bitmap bit at a time through the single bitmap read port, and
//   each block marked or cleared is one bitmap write.
//   after reset the bitmap is cleared one block per cycle, and no request is accepted
//   meanwhile; counters reset to zero used, total_blocks 4096.
//   the answer sits in an output register: the next request is accepted while it waits,
//   and a finished answer holds the block until the receiver has taken the previous one.
//   BLOCK_BYTES must be a power of two.
module bitmap_first_fit_allocator_core #(
    parameter int BLOCK_BYTES = bffa_pkg::DEF_BLOCK_BYTES,
    parameter int MAP_BLOCKS  = bffa_pkg::DEF_MAP_BLOCKS,
    parameter int MAX_ENTRIES = bffa_pkg::DEF_MAX_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // func
    input  logic [143:0] s_tdata,   // owner, size_bytes, alignment_bytes, start_address,
                                    // end_address
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // status
    output logic [111:0] m_tdata,   // block_address, used_bytes, free_bytes, entries_used,
                                    // zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [bffa_pkg::TOTAL_W-1:0] cfg_data
);

    localparam int SH    = $clog2(BLOCK_BYTES);
    localparam int MAP_W = $clog2(MAP_BLOCKS);
    localparam int ENT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_E = $clog2(MAX_ENTRIES + 1);
    localparam int RUN_W = $clog2(MAP_BLOCKS + 1);

    // memories
    logic                   map_mem [MAP_BLOCKS];
    bffa_pkg::entry_t       tbl_mem [MAX_ENTRIES];

    logic                   map_we;
    logic [MAP_W-1:0]       map_wa;
    logic                   map_wd;
    logic [MAP_W-1:0]       map_ra;
    logic                   map_q;

    logic                   tbl_we;
    logic [ENT_W-1:0]       tbl_wa;
    bffa_pkg::entry_t       tbl_wd;
    logic [ENT_W-1:0]       tbl_ra;
    bffa_pkg::entry_t       tbl_q;

    // control and counters
    bffa_pkg::state_t       state_reg, state_next;
    logic [MAP_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [bffa_pkg::TOTAL_W-1:0] total_blocks_reg, total_blocks_next;
    logic [31:0]            used_reg, used_next;
    logic [31:0]            free_reg, free_next;
    logic [CNT_E-1:0]       ecount_reg, ecount_next;
    logic [32:0]            scan_reg, scan_next;
    logic [31:0]            phase_reg, phase_next;
    logic [RUN_W-1:0]       run_reg, run_next;
    logic [MAP_W-1:0]       run_start_reg, run_start_next;
    logic [CNT_E-1:0]       idx_reg, idx_next;
    logic [31:0]            mk_start_reg, mk_start_next;
    logic [31:0]            mk_end_reg, mk_end_next;
    logic                   mk_set_reg, mk_set_next;
    logic [MAP_W-1:0]       mark_idx_reg, mark_idx_next;
    logic [MAP_W-1:0]       mark_last_reg, mark_last_next;
    bffa_pkg::status_t      status_reg, status_next;
    logic [31:0]            addr_reg, addr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             m_status_reg, m_status_next;
    logic [111:0]           m_data_reg, m_data_next;

    // request payload
    bffa_pkg::func_t        func_reg;
    logic [15:0]            owner_reg;
    logic [31:0]            size_reg;
    logic [31:0]            align_reg;
    logic [31:0]            start_reg;
    logic [31:0]            end_reg;

    logic                   in_load;
    logic                   out_load;

    // derived terms
    logic [32:0]            size_rnd;
    logic [32:0]            req_blk;
    logic [32:0]            req_bytes;
    logic                   align_bad;
    logic                   no_mem;
    logic                   tbl_full;
    logic [31:0]            ablk;
    logic [32:0]            limit;
    logic                   scan_done;
    logic [RUN_W-1:0]       run_inc;
    logic                   run_hit;
    logic [MAP_W-1:0]       base_blk;
    logic [63:0]            base_wide;
    logic [31:0]            alloc_start;
    logic [31:0]            alloc_end;
    logic [32:0]            scan_skip;
    logic [31:0]            phase_inc;
    logic [31:0]            first_blk;
    logic [31:0]            last_raw;
    logic [31:0]            last_cl;
    logic                   mk_empty;
    logic                   tbl_hit;
    logic [31:0]            drop_bytes;
    logic [31:0]            add_bytes_res;
    logic [31:0]            add_bytes_alloc;
    logic                   move_needed;
    logic [CNT_E-1:0]       last_idx;
    logic                   is_release;
    logic [63:0]            cfg_wide;

    assign s_tready  = (state_reg == bffa_pkg::S_IDLE);
    assign in_load   = s_tvalid && s_tready;
    assign out_load  = (state_reg == bffa_pkg::S_FIN) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign size_rnd   = 33'(size_reg) + 33'(BLOCK_BYTES - 1);
    assign req_blk    = size_rnd >> SH;
    assign req_bytes  = size_rnd & ~33'(BLOCK_BYTES - 1);
    assign align_bad  = (align_reg[SH-1:0] != '0);
    assign no_mem     = req_bytes[32] || (req_bytes[31:0] > free_reg);
    assign tbl_full   = (ecount_reg >= CNT_E'(MAX_ENTRIES));
    assign ablk       = align_reg >> SH;
    assign limit      = (33'(total_blocks_reg) < 33'(MAP_BLOCKS)) ? 33'(total_blocks_reg)
                                                                  : 33'(MAP_BLOCKS);
    assign scan_done  = (scan_reg >= limit);
    assign run_inc    = run_reg + RUN_W'(1);
    assign run_hit    = (33'(run_inc) >= req_blk);
    assign base_blk   = (run_reg == '0) ? scan_reg[MAP_W-1:0] : run_start_reg;
    assign base_wide  = 64'(base_blk) << SH;
    assign alloc_start = base_wide[31:0];
    assign alloc_end  = alloc_start + req_bytes[31:0] - 32'd1;
    // jump to the next alignment boundary after a used block
    assign scan_skip  = scan_reg + 33'(ablk) - 33'(phase_reg);
    assign phase_inc  = phase_reg + 32'd1;

    assign first_blk  = mk_start_reg >> SH;
    assign last_raw   = mk_end_reg >> SH;
    assign last_cl    = (last_raw > 32'(MAP_BLOCKS - 1)) ? 32'(MAP_BLOCKS - 1) : last_raw;
    assign mk_empty   = (first_blk > last_cl);

    assign tbl_hit    = (func_reg == bffa_pkg::FN_REL_START) ? (tbl_q.start_addr == start_reg)
                                                             : (tbl_q.owner == owner_reg);
    assign drop_bytes      = tbl_q.end_addr - tbl_q.start_addr + 32'd1;
    assign add_bytes_res   = end_reg - start_reg + 32'd1;
    assign add_bytes_alloc = req_bytes[31:0];
    assign move_needed = ((idx_reg + CNT_E'(1)) < ecount_reg);
    assign last_idx    = ecount_reg - CNT_E'(1);
    assign is_release  = (func_reg == bffa_pkg::FN_REL_START) ||
                         (func_reg == bffa_pkg::FN_REL_OWNER);
    assign cfg_wide    = 64'(cfg_data) << SH;

    assign map_ra = scan_reg[MAP_W-1:0];
    assign tbl_ra = (state_reg == bffa_pkg::S_POST) ? last_idx[ENT_W-1:0] : idx_reg[ENT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bffa_pkg::S_CLEAR:
            begin
                if (clr_idx_reg == MAP_W'(MAP_BLOCKS - 1))
                    state_next = bffa_pkg::S_IDLE;
            end
            bffa_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = bffa_pkg::S_EXEC;
            end
            bffa_pkg::S_EXEC:
            begin
                unique case (func_reg)
                    bffa_pkg::FN_ALLOC:
                    begin
                        if (size_reg == '0 || tbl_full || align_bad || no_mem)
                            state_next = bffa_pkg::S_FIN;
                        else
                            state_next = bffa_pkg::S_ALLOC_RD;
                    end
                    bffa_pkg::FN_RESERVE:
                    begin
                        state_next = tbl_full ? bffa_pkg::S_FIN : bffa_pkg::S_MK_SET;
                    end
                    bffa_pkg::FN_REL_START: state_next = bffa_pkg::S_TBL_RD;
                    bffa_pkg::FN_REL_OWNER: state_next = bffa_pkg::S_TBL_RD;
                endcase
            end
            bffa_pkg::S_ALLOC_RD:
            begin
                state_next = scan_done ? bffa_pkg::S_FIN : bffa_pkg::S_ALLOC_EV;
            end
            bffa_pkg::S_ALLOC_EV:
            begin
                state_next = (!map_q && run_hit) ? bffa_pkg::S_MK_SET : bffa_pkg::S_ALLOC_RD;
            end
            bffa_pkg::S_TBL_RD:
            begin
                state_next = (idx_reg >= ecount_reg) ? bffa_pkg::S_FIN : bffa_pkg::S_TBL_EV;
            end
            bffa_pkg::S_TBL_EV:
            begin
                state_next = tbl_hit ? bffa_pkg::S_MK_SET : bffa_pkg::S_TBL_RD;
            end
            bffa_pkg::S_MK_SET:
            begin
                state_next = mk_empty ? bffa_pkg::S_POST : bffa_pkg::S_MARK;
            end
            bffa_pkg::S_MARK:
            begin
                if (mark_idx_reg == mark_last_reg)
                    state_next = bffa_pkg::S_POST;
            end
            bffa_pkg::S_POST:
            begin
                priority if (!is_release)
                    state_next = bffa_pkg::S_FIN;
                else if (move_needed)
                    state_next = bffa_pkg::S_MOVE_WR;
                else if (func_reg == bffa_pkg::FN_REL_START)
                    state_next = bffa_pkg::S_FIN;
                else
                    state_next = bffa_pkg::S_TBL_RD;
            end
            bffa_pkg::S_MOVE_WR:
            begin
                state_next = (func_reg == bffa_pkg::FN_REL_START) ? bffa_pkg::S_FIN
                                                                  : bffa_pkg::S_TBL_RD;
            end
            bffa_pkg::S_FIN:
            begin
                if (out_load)
                    state_next = bffa_pkg::S_IDLE;
            end
            default: state_next = bffa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_idx_next      = clr_idx_reg;
        total_blocks_next = total_blocks_reg;
        used_next         = used_reg;
        free_next         = free_reg;
        ecount_next       = ecount_reg;
        scan_next         = scan_reg;
        phase_next        = phase_reg;
        run_next          = run_reg;
        run_start_next    = run_start_reg;
        idx_next          = idx_reg;
        mk_start_next     = mk_start_reg;
        mk_end_next       = mk_end_reg;
        mk_set_next       = mk_set_reg;
        mark_idx_next     = mark_idx_reg;
        mark_last_next    = mark_last_reg;
        status_next       = status_reg;
        addr_next         = addr_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_status_next     = m_status_reg;
        m_data_next       = m_data_reg;
        map_we            = 1'b0;
        map_wa            = mark_idx_reg;
        map_wd            = mk_set_reg;
        tbl_we            = 1'b0;
        tbl_wa            = ecount_reg[ENT_W-1:0];
        tbl_wd            = '{owner: owner_reg, start_addr: start_reg, end_addr: end_reg};

        unique case (state_reg)
            bffa_pkg::S_CLEAR:
            begin
                map_we       = 1'b1;
                map_wa       = clr_idx_reg;
                map_wd       = 1'b0;
                clr_idx_next = clr_idx_reg + MAP_W'(1);
            end
            bffa_pkg::S_IDLE:
            begin
                status_next = bffa_pkg::STAT_OK;
                addr_next   = '0;
            end
            bffa_pkg::S_EXEC:
            begin
                unique case (func_reg)
                    bffa_pkg::FN_ALLOC:
                    begin
                        mk_set_next = 1'b1;
                        priority if (size_reg == '0)
                            status_next = bffa_pkg::STAT_BAD_SIZE;
                        else if (tbl_full)
                            status_next = bffa_pkg::STAT_TABLE_FULL;
                        else if (align_bad)
                            status_next = bffa_pkg::STAT_BAD_ALIGN;
                        else if (no_mem)
                            status_next = bffa_pkg::STAT_NO_MEM;
                        else
                        begin
                            scan_next  = '0;
                            run_next   = '0;
                            phase_next = '0;
                        end
                    end
                    bffa_pkg::FN_RESERVE:
                    begin
                        mk_set_next = 1'b1;
                        if (tbl_full)
                            status_next = bffa_pkg::STAT_TABLE_FULL;
                        else
                        begin
                            tbl_we        = 1'b1;
                            ecount_next   = ecount_reg + CNT_E'(1);
                            used_next     = used_reg + add_bytes_res;
                            free_next     = free_reg - add_bytes_res;
                            addr_next     = start_reg;
                            mk_start_next = start_reg;
                            mk_end_next   = end_reg;
                        end
                    end
                    bffa_pkg::FN_REL_START:
                    begin
                        status_next = bffa_pkg::STAT_NO_ENTRY;
                        idx_next    = '0;
                        mk_set_next = 1'b0;
                    end
                    bffa_pkg::FN_REL_OWNER:
                    begin
                        status_next = bffa_pkg::STAT_OK;
                        idx_next    = '0;
                        mk_set_next = 1'b0;
                    end
                endcase
            end
            bffa_pkg::S_ALLOC_RD:
            begin
                if (scan_done)
                    status_next = bffa_pkg::STAT_NO_MEM;
            end
            bffa_pkg::S_ALLOC_EV:
            begin
                priority if (map_q)
                begin
                    run_next   = '0;
                    phase_next = '0;
                    scan_next  = (ablk != '0) ? scan_skip : scan_reg + 33'd1;
                end
                else if (run_hit)
                begin
                    tbl_wd        = '{owner: owner_reg, start_addr: alloc_start,
                                      end_addr: alloc_end};
                    tbl_we        = 1'b1;
                    ecount_next   = ecount_reg + CNT_E'(1);
                    used_next     = used_reg + add_bytes_alloc;
                    free_next     = free_reg - add_bytes_alloc;
                    addr_next     = alloc_start;
                    mk_start_next = alloc_start;
                    mk_end_next   = alloc_end;
                end
                else
                begin
                    run_start_next = base_blk;
                    run_next       = run_inc;
                    scan_next      = scan_reg + 33'd1;
                    phase_next     = (phase_inc == ablk) ? '0 : phase_inc;
                end
            end
            bffa_pkg::S_TBL_RD:
            begin
            end
            bffa_pkg::S_TBL_EV:
            begin
                if (tbl_hit)
                begin
                    status_next   = bffa_pkg::STAT_OK;
                    used_next     = used_reg - drop_bytes;
                    free_next     = free_reg + drop_bytes;
                    mk_start_next = tbl_q.start_addr;
                    mk_end_next   = tbl_q.end_addr;
                end
                else
                    idx_next = idx_reg + CNT_E'(1);
            end
            bffa_pkg::S_MK_SET:
            begin
                mark_idx_next  = first_blk[MAP_W-1:0];
                mark_last_next = last_cl[MAP_W-1:0];
            end
            bffa_pkg::S_MARK:
            begin
                map_we        = 1'b1;
                mark_idx_next = mark_idx_reg + MAP_W'(1);
            end
            bffa_pkg::S_POST:
            begin
                // the last entry is read here and moved into the freed slot next cycle
                if (is_release && !move_needed)
                    ecount_next = ecount_reg - CNT_E'(1);
            end
            bffa_pkg::S_MOVE_WR:
            begin
                tbl_we      = 1'b1;
                tbl_wa      = idx_reg[ENT_W-1:0];
                tbl_wd      = tbl_q;
                ecount_next = ecount_reg - CNT_E'(1);
            end
            bffa_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = {7'd0, 9'(ecount_reg), free_reg, used_reg, addr_reg};
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_valid)
        begin
            total_blocks_next = cfg_data;
            free_next         = cfg_wide[31:0] - used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bffa_pkg::S_CLEAR;
            clr_idx_reg      <= '0;
            total_blocks_reg <= bffa_pkg::TOTAL_W'(bffa_pkg::RESET_TOTAL_BLOCKS);
            used_reg         <= '0;
            free_reg         <= 32'(64'(bffa_pkg::RESET_TOTAL_BLOCKS) << SH);
            ecount_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            total_blocks_reg <= total_blocks_next;
            used_reg         <= used_next;
            free_reg         <= free_next;
            ecount_reg       <= ecount_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        phase_reg     <= phase_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        idx_reg       <= idx_next;
        mk_start_reg  <= mk_start_next;
        mk_end_reg    <= mk_end_next;
        mk_set_reg    <= mk_set_next;
        mark_idx_reg  <= mark_idx_next;
        mark_last_reg <= mark_last_next;
        status_reg    <= status_next;
        addr_reg      <= addr_next;
        m_status_reg  <= m_status_next;
        m_data_reg    <= m_data_next;
        if (in_load)
        begin
            func_reg  <= bffa_pkg::func_t'(s_tuser);
            owner_reg <= s_tdata[15:0];
            size_reg  <= s_tdata[47:16];
            align_reg <= s_tdata[79:48];
            start_reg <= s_tdata[111:80];
            end_reg   <= s_tdata[143:112];
        end
    end

    // used-block bitmap
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        map_q <= map_mem[map_ra];
    end

    // entry table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_wa] <= tbl_wd;
        tbl_q <= tbl_mem[tbl_ra];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ecount_reg <= CNT_E'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg + free_reg) == 32'(64'(total_blocks_reg) << SH))
        else $error("used and free bytes do not add up to the managed size");

    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bffa_pkg::S_MARK |-> mark_idx_reg <= mark_last_reg)
        else $error("bitmap marking ran past its last block");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (ecount_reg == $past(ecount_reg)) ||
                 (ecount_reg == $past(ecount_reg) + CNT_E'(1)) ||
                 (ecount_reg == $past(ecount_reg) - CNT_E'(1)))
        else $error("entry count moved by more than one");
`endif

endmodule

// ===== dv/bffa_checker.sv =====
// bffa_checker: watches the request, answer and config channels of the allocator core,
// predicts every answer word and compares it field by field; depends on bffa_pkg
module bffa_checker #(
    parameter int BLOCK_BYTES = bffa_pkg::DEF_BLOCK_BYTES,
    parameter int MAP_BLOCKS  = bffa_pkg::DEF_MAP_BLOCKS,
    parameter int MAX_ENTRIES = bffa_pkg::DEF_MAX_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [1:0]         s_tuser,
    input  logic [143:0]       s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [2:0]         m_tuser,
    input  logic [111:0]       m_tdata,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [bffa_pkg::TOTAL_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 answer_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bffa_pkg::status_t status;
        logic [31:0] block_address;
        logic [31:0] used_bytes;
        logic [31:0] free_bytes;
        logic [8:0]  entries_used;
    } answer_t;

    answer_t     answer_q[$];
    bit          block_busy[MAP_BLOCKS];
    logic [15:0] ent_owner[MAX_ENTRIES];
    logic [31:0] ent_start[MAX_ENTRIES];
    logic [31:0] ent_end[MAX_ENTRIES];
    int unsigned ent_count;
    logic [31:0] used_sum;
    logic [31:0] free_sum;
    logic [31:0] total_blocks;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void mark_blocks(input logic [31:0] first, input logic [31:0] last,
                                        input bit val);
        longint unsigned b;
        longint unsigned top;
        b   = first / BLOCK_BYTES;
        top = last / BLOCK_BYTES;
        if (top > MAP_BLOCKS - 1)
            top = MAP_BLOCKS - 1;
        for (; b <= top; b++)
            block_busy[b] = val;
    endfunction

    function automatic void add_entry(input logic [15:0] own, input logic [31:0] first,
                                      input logic [31:0] last);
        logic [31:0] bytes;
        bytes = last - first + 32'd1;
        ent_owner[ent_count] = own;
        ent_start[ent_count] = first;
        ent_end[ent_count]   = last;
        used_sum += bytes;
        free_sum -= bytes;
        ent_count++;
        mark_blocks(first, last, 1'b1);
    endfunction

    function automatic void drop_entry(input int unsigned i);
        logic [31:0] bytes;
        bytes = ent_end[i] - ent_start[i] + 32'd1;
        mark_blocks(ent_start[i], ent_end[i], 1'b0);
        used_sum -= bytes;
        free_sum += bytes;
        if (i + 1 < ent_count)
        begin
            ent_owner[i] = ent_owner[ent_count-1];
            ent_start[i] = ent_start[ent_count-1];
            ent_end[i]   = ent_end[ent_count-1];
        end
        ent_count--;
    endfunction

    function automatic bffa_pkg::status_t first_fit(input logic [15:0] own,
                                                    input logic [31:0] size,
                                                    input logic [31:0] align,
                                                    output logic [31:0] addr);
        longint unsigned need;
        longint unsigned span;
        longint unsigned blk;
        longint unsigned run;
        longint unsigned align_blocks;
        logic [31:0]     first;
        addr = 32'd0;
        run  = 0;
        if (size == 32'd0)
            return bffa_pkg::STAT_BAD_SIZE;
        if (ent_count >= MAX_ENTRIES)
            return bffa_pkg::STAT_TABLE_FULL;
        if (align != 32'd0 && (align % BLOCK_BYTES) != 0)
            return bffa_pkg::STAT_BAD_ALIGN;
        need = ((longint'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
        if (need > 64'hFFFF_FFFF || need > longint'(free_sum))
            return bffa_pkg::STAT_NO_MEM;
        align_blocks = align / BLOCK_BYTES;
        span = (total_blocks < MAP_BLOCKS) ? total_blocks : MAP_BLOCKS;
        for (blk = 0; blk < span; blk++)
        begin
            if (block_busy[blk])
            begin
                run = 0;
                // restart at the next alignment boundary
                if (align_blocks != 0)
                    blk += (align_blocks - (blk % align_blocks)) - 1;
                continue;
            end
            run++;
            if (run * BLOCK_BYTES >= need)
            begin
                first = 32'((blk - (run - 1)) * BLOCK_BYTES);
                add_entry(own, first, first + 32'(need) - 32'd1);
                addr = first;
                return bffa_pkg::STAT_OK;
            end
        end
        return bffa_pkg::STAT_NO_MEM;
    endfunction

    function automatic answer_t predict_answer(input bffa_pkg::func_t fn,
                                               input logic [143:0] word);
        answer_t     ans;
        logic [15:0] own;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] first;
        logic [31:0] last;
        int unsigned i;
        own   = word[15:0];
        size  = word[47:16];
        align = word[79:48];
        first = word[111:80];
        last  = word[143:112];
        ans.status        = bffa_pkg::STAT_OK;
        ans.block_address = 32'd0;
        case (fn)
            bffa_pkg::FN_ALLOC:
                ans.status = first_fit(own, size, align, ans.block_address);
            bffa_pkg::FN_RESERVE:
                if (ent_count >= MAX_ENTRIES)
                    ans.status = bffa_pkg::STAT_TABLE_FULL;
                else
                begin
                    add_entry(own, first, last);
                    ans.block_address = first;
                end
            bffa_pkg::FN_REL_START:
            begin
                ans.status = bffa_pkg::STAT_NO_ENTRY;
                for (i = 0; i < ent_count; i++)
                    if (ent_start[i] == first)
                    begin
                        drop_entry(i);
                        ans.status = bffa_pkg::STAT_OK;
                        break;
                    end
            end
            default:
            begin
                i = 0;
                while (i < ent_count)
                    if (ent_owner[i] == own)
                        drop_entry(i);
                    else
                        i++;
            end
        endcase
        ans.used_bytes   = used_sum;
        ans.free_bytes   = free_sum;
        ans.entries_used = ent_count[8:0];
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            answer_q.delete();
            foreach (block_busy[k])
                block_busy[k] = 1'b0;
            ent_count    = 0;
            used_sum     = 32'd0;
            total_blocks = bffa_pkg::RESET_TOTAL_BLOCKS;
            free_sum     = 32'(total_blocks * BLOCK_BYTES);
            fail_count   = 0;
            pending      = 0;
            answer_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                answer_count++;
                if (answer_q.size() == 0)
                    report("answer word with nothing outstanding", 32'(m_tuser), 32'd0);
                else
                begin
                    want = answer_q.pop_front();
                    if (m_tuser !== want.status)
                        report("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.block_address)
                        report("block_address", m_tdata[31:0], want.block_address);
                    if (m_tdata[63:32] !== want.used_bytes)
                        report("used_bytes", m_tdata[63:32], want.used_bytes);
                    if (m_tdata[95:64] !== want.free_bytes)
                        report("free_bytes", m_tdata[95:64], want.free_bytes);
                    if (m_tdata[104:96] !== want.entries_used)
                        report("entries_used", 32'(m_tdata[104:96]), 32'(want.entries_used));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                total_blocks = 32'(cfg_data);
                free_sum     = 32'(total_blocks * BLOCK_BYTES) - used_sum;
            end
            if (s_tvalid && s_tready)
                answer_q.push_back(predict_answer(bffa_pkg::func_t'(s_tuser), s_tdata));
            pending = answer_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// testbench: drives requests and total_blocks settings into bitmap_first_fit_allocator_core
// with random idling on both sides; checking lives in bffa_checker; depends on bffa_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BB = bffa_pkg::DEF_BLOCK_BYTES;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [1:0]         s_tuser;
    logic [143:0]       s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [2:0]         m_tuser;
    logic [111:0]       m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [bffa_pkg::TOTAL_W-1:0] cfg_data;
    int                 fail_count;
    int                 pending;
    int                 answer_count;
    bit                 gaps_on;
    int                 settings_done;
    logic [31:0]        granted_q[$];
    logic [15:0]        odd_owner_q[$];

    bitmap_first_fit_allocator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    bffa_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .answer_count(answer_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("timeout with %0d answers outstanding", pending);
        $display("FAIL bitmap_first_fit_allocator_core");
        $finish;
    end

    // remember granted start addresses so releases hit live entries
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready && m_tuser == bffa_pkg::STAT_OK &&
            m_tdata[31:0] != 32'd0)
            granted_q.push_back(m_tdata[31:0]);

    // receiver stalls in bursts
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic send(input bffa_pkg::func_t fn, input logic [15:0] own,
                        input logic [31:0] size, input logic [31:0] align,
                        input logic [31:0] first, input logic [31:0] last);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {last, first, align, size, own};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic set_total(input logic [bffa_pkg::TOTAL_W-1:0] blocks);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = blocks;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_done++;
    endtask

    task automatic release_owners();
        for (int o = 0; o < 8; o++)
            send(bffa_pkg::FN_REL_OWNER, 16'(o), $urandom, $urandom, $urandom, $urandom);
        while (odd_owner_q.size() != 0)
            send(bffa_pkg::FN_REL_OWNER, odd_owner_q.pop_front(), 32'd0, 32'd0, 32'd0,
                 32'd0);
        granted_q.delete();
    endtask

    task automatic random_request(input int span);
        logic [15:0] own;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] first;
        logic [31:0] last;
        int          pick;
        int          idx;
        own = 16'($urandom_range(0, 7));
        if ($urandom_range(0, 15) == 0)
        begin
            own = 16'($urandom);
            odd_owner_q.push_back(own);
        end
        size  = $urandom_range(1, 6 * BB);
        align = 32'(BB * $urandom_range(0, 3) * (1 << $urandom_range(0, 2)));
        first = 32'(BB * $urandom_range(0, span)) + $urandom_range(0, 3) * 32'(BB / 4);
        last  = first + $urandom_range(0, 3 * BB);
        pick  = $urandom_range(0, 99);
        if (pick < 40)
        begin
            case ($urandom_range(0, 19))
                0: size = $urandom;
                1: size = 32'd0;
                2: align = $urandom;
                3: align = 32'(BB * $urandom_range(1, 1 << 19));
                default: ;
            endcase
            send(bffa_pkg::FN_ALLOC, own, size, align, $urandom, $urandom);
        end
        else if (pick < 62)
        begin
            if ($urandom_range(0, 63) == 0)
            begin
                first = $urandom;
                last  = $urandom;
            end
            send(bffa_pkg::FN_RESERVE, own, $urandom, $urandom, first, last);
        end
        else if (pick < 92)
        begin
            if (granted_q.size() != 0 && $urandom_range(0, 7) != 0)
            begin
                idx   = $urandom_range(0, granted_q.size() - 1);
                first = granted_q[idx];
                granted_q.delete(idx);
            end
            else if ($urandom_range(0, 1) == 0)
                first = $urandom;
            send(bffa_pkg::FN_REL_START, own, $urandom, $urandom, first, $urandom);
        end
        else
            send(bffa_pkg::FN_REL_OWNER, own, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        logic [bffa_pkg::TOTAL_W-1:0] settings[8];
        int                 counts[8];
        int                 span;
        settings = '{13'd1, 13'd0, 13'd64, 13'd8191, 13'd16, 13'd4096, 13'd256, 13'd32};
        counts   = '{100, 50, 280, 120, 240, 120, 280, 250};
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = bffa_pkg::FN_ALLOC;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        settings_done = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // bitmap clear pass must finish before the first config write
        do @(posedge clk); while (!s_tready);

        // directed part at the reset size
        set_total(13'd4096);
        send(bffa_pkg::FN_ALLOC, 16'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_ALLOC, 16'd1, 32'd4096, 32'd100, 32'd0, 32'd0);
        send(bffa_pkg::FN_ALLOC, 16'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_ALLOC, 16'd1, 32'h0200_0000, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_ALLOC, 16'hFFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(bffa_pkg::FN_ALLOC, 16'd2, 32'd3 * BB, 32'h4000, 32'd0, 32'd0);
        send(bffa_pkg::FN_ALLOC, 16'd2, 32'd5000, 32'd4096, 32'd0, 32'd0);
        send(bffa_pkg::FN_RESERVE, 16'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0FFF);
        send(bffa_pkg::FN_ALLOC, 16'd3, 32'd1, 32'hFFFF_F000, 32'd0, 32'd0);
        send(bffa_pkg::FN_RESERVE, 16'd0, 32'd0, 32'd0, 32'h0002_0000, 32'h0000_1000);
        send(bffa_pkg::FN_RESERVE, 16'd0, 32'd0, 32'd0, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send(bffa_pkg::FN_RESERVE, 16'd4, 32'd0, 32'd0, 32'h0000_8000, 32'h0000_9FFF);
        send(bffa_pkg::FN_ALLOC, 16'd4, 32'd2 * BB, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_REL_START, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_REL_START, 16'd0, 32'd0, 32'd0, 32'h0001_2345, 32'd0);
        send(bffa_pkg::FN_REL_START, 16'd0, 32'd0, 32'd0, 32'h0000_8000, 32'd0);
        send(bffa_pkg::FN_REL_OWNER, 16'h1234, 32'd0, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_REL_OWNER, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0);
        for (int o = 0; o < 5; o++)
            send(bffa_pkg::FN_REL_OWNER, 16'(o), 32'd0, 32'd0, 32'd0, 32'd0);

        // fill the entry table, then hit the table-full checks
        set_total(13'd64);
        for (int i = 0; i < bffa_pkg::DEF_MAX_ENTRIES; i++)
            send(bffa_pkg::FN_RESERVE, 16'd5, 32'd0, 32'd0, 32'h0100_0000 + 32'(i * BB),
                 32'h0100_0000 + 32'(i * BB) + 32'd15);
        send(bffa_pkg::FN_ALLOC, 16'd5, 32'd1, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_RESERVE, 16'd5, 32'd0, 32'd0, 32'd0, 32'd0);
        send(bffa_pkg::FN_REL_OWNER, 16'd5, 32'd0, 32'd0, 32'd0, 32'd0);
        granted_q.delete();

        for (int p = 0; p < 8; p++)
        begin
            set_total(settings[p]);
            span = (settings[p] == 0) ? 8 : ((settings[p] > 64) ? 64 : int'(settings[p]));
            for (int n = 0; n < counts[p]; n++)
            begin
                if (p == 7 && n > counts[p] / 3)
                    gaps_on = 1'b0;
                random_request(span);
            end
            release_owners();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d answers across %0d total_blocks settings", answer_count,
                 settings_done);
        $display("allocate, reserve and both release kinds, idling on both channels");
        if (fail_count == 0)
            $display("PASS bitmap_first_fit_allocator_core");
        else
            $display("FAIL bitmap_first_fit_allocator_core");
        $finish;
    end

endmodule
